FILE: hw/rtl/vts_pkg.sv
// Shared types and constants for the vertex transform stage.
// Used by the channel interfaces, the controller, the datapath and the top level.
// No dependencies.
package vts_pkg;

	// fixed-point format and primitive size
	localparam int FRAC_BITS      = 16;
	localparam int VERTS_PER_PRIM = 3;
	localparam int COEF_W         = 32;
	localparam int ATTR_W         = 2;
	localparam int SLOT_W         = 2;

	// matrix geometry: two matrices of four rows, four lanes per row
	localparam int LANES    = 4;
	localparam int ROW_AW   = 3;
	localparam int MAT_ROWS = 8;

	// 1.0 in the coefficient format
	localparam logic signed [COEF_W-1:0] FIX_ONE = 32'sh1 << FRAC_BITS;

	// opcodes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_VERTEX = 1'b1;

	// attribute mask bits
	localparam int ATTR_COLOR_BIT = 0;
	localparam int ATTR_TEX_BIT   = 1;

	// input beat
	typedef struct packed {
		logic               opcode;
		logic [4:0]         coef_index;
		logic signed [31:0] coef_value;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
		logic [31:0]        color_r;
		logic [31:0]        color_g;
		logic [31:0]        color_b;
		logic [31:0]        color_a;
		logic [31:0]        tex_u;
		logic [31:0]        tex_v;
	} vts_in_t;

	// result beat
	typedef struct packed {
		logic signed [31:0] clip_x;
		logic signed [31:0] clip_y;
		logic signed [31:0] clip_z;
		logic signed [31:0] clip_w;
		logic [31:0]        out_color_r;
		logic [31:0]        out_color_g;
		logic [31:0]        out_color_b;
		logic [31:0]        out_color_a;
		logic [31:0]        out_tex_u;
		logic [31:0]        out_tex_v;
		logic               triangle_last;
		logic               overflow;
	} vts_out_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic              coef_wr;   // store one coefficient from the input beat
		logic              capture;   // latch a vertex beat
		logic              issue;     // read one matrix row into the dot product unit
		logic [ROW_AW-1:0] issue_row; // {matrix, row}; matrix 1 is projection
		logic              load_out;  // move the finished vertex to the output register
	} vts_cmd_t;

endpackage

FILE: hw/rtl/vts_in_if.sv
// Input channel: valid/ready handshake carrying one load or vertex beat.
// Depends on vts_pkg.
interface vts_in_if;
	logic            valid;
	logic            ready;
	vts_pkg::vts_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/vts_out_if.sv
// Result channel: valid/ready handshake carrying one transformed vertex.
// Depends on vts_pkg.
interface vts_out_if;
	logic             valid;
	logic             ready;
	vts_pkg::vts_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/vts_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the attribute mask.
// Depends on vts_pkg.
interface vts_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [vts_pkg::ATTR_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: hw/rtl/vts_ctrl.sv
// Controller of the vertex transform stage: sequences row reads for the
// model and projection passes and owns the input and output handshakes.
// Depends on vts_pkg.
module vts_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_opcode,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output vts_pkg::vts_cmd_t cmd
);
	import vts_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	// sequence timing: model rows issue at 0..3, projection rows at 6..9,
	// the last projection result lands at the end of step 11
	localparam logic [3:0] MODEL_END  = 4'd4;
	localparam logic [3:0] PROJ_FIRST = 4'd6;
	localparam logic [3:0] PROJ_END   = 4'd10;
	localparam logic [3:0] CNT_LAST   = 4'd11;

	state_t     state_q;
	logic [3:0] cnt_q;
	logic [3:0] proj_cnt;
	logic       out_valid_q;
	logic       accept;
	logic       out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign proj_cnt = cnt_q - PROJ_FIRST;

	// decode commands
	always_comb begin
		cmd           = '0;
		cmd.coef_wr   = accept && (in_opcode == OP_LOAD);
		cmd.capture   = accept && (in_opcode == OP_VERTEX);
		cmd.load_out  = (state_q == ST_DONE) && out_free;
		if (state_q == ST_RUN) begin
			if (cnt_q < MODEL_END) begin
				cmd.issue     = 1'b1;
				cmd.issue_row = {1'b0, cnt_q[1:0]};
			end else if (cnt_q >= PROJ_FIRST && cnt_q < PROJ_END) begin
				cmd.issue     = 1'b1;
				cmd.issue_row = {1'b1, proj_cnt[1:0]};
			end
		end
	end

	// advance the state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (cmd.capture) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == CNT_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// hold the result beat until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

FILE: hw/rtl/vts_dp.sv
// Datapath of the vertex transform stage: coefficient memory, four-lane
// dot product unit, saturation, vertex registers and the output register.
// Depends on vts_pkg.
module vts_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  vts_pkg::vts_cmd_t           cmd,
	input  vts_pkg::vts_in_t            in_data,
	input  logic                        cfg_wr,
	input  logic [vts_pkg::ATTR_W-1:0] cfg_data,
	output vts_pkg::vts_out_t           out_data
);
	import vts_pkg::*;

	localparam int PROD_W = 2 * COEF_W;
	localparam int SUM_W  = PROD_W + 2;
	localparam int SH_W   = SUM_W - FRAC_BITS;
	localparam logic signed [SH_W-1:0] SAT_HI = SH_W'(64'sh7FFF_FFFF);
	localparam logic signed [SH_W-1:0] SAT_LO = SH_W'(-64'sh8000_0000);
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(VERTS_PER_PRIM - 1);

	// coefficient memory: one row of four lanes per entry
	logic [LANES-1:0][COEF_W-1:0] coef_mem [MAT_ROWS];
	logic [MAT_ROWS-1:0]          row_vld_q;
	logic [ROW_AW-1:0]            wr_addr;
	logic [1:0]                   wr_row;
	logic [1:0]                   wr_col;

	// configuration and primitive tracking
	logic [ATTR_W-1:0] attr_q;
	logic [SLOT_W-1:0] slot_q;
	logic              slot_last;

	// latched vertex
	logic signed [COEF_W-1:0] pos_q [3];
	logic [31:0]              color_q [4];
	logic [31:0]              tex_q [2];
	logic                     last_q;

	// intermediate and final vectors
	logic signed [COEF_W-1:0] mid_q [LANES];
	logic signed [COEF_W-1:0] clip_q [LANES];
	logic                     ovf_q;

	// pipeline: row read, products, sum and saturate
	logic                         v_s1;
	logic [ROW_AW-1:0]            row_s1;
	logic                         vld_s1;
	logic [LANES-1:0][COEF_W-1:0] rd_s1;
	logic signed [COEF_W-1:0]     coef_s1 [LANES];
	logic signed [COEF_W-1:0]     vec_s1 [LANES];
	logic signed [PROD_W-1:0]     prod_s1 [LANES];
	logic                         v_s2;
	logic [ROW_AW-1:0]            row_s2;
	logic signed [PROD_W-1:0]     prod_s2 [LANES];
	logic signed [SUM_W-1:0]      sum_s2;
	logic signed [SH_W-1:0]       sh_s2;
	logic signed [COEF_W-1:0]     sat_s2;
	logic                         ovf_s2;

	assign wr_addr   = {in_data.coef_index[4], in_data.coef_index[3:2]};
	assign wr_row    = in_data.coef_index[3:2];
	assign wr_col    = in_data.coef_index[1:0];
	assign slot_last = (slot_q >= SLOT_LAST);

	// write one lane; a row never written before takes identity in the other lanes
	always_ff @(posedge clk) begin
		if (cmd.coef_wr) begin
			for (int l = 0; l < LANES; l++) begin
				if (l == int'(wr_col)) begin
					coef_mem[wr_addr][l] <= in_data.coef_value;
				end else if (!row_vld_q[wr_addr]) begin
					coef_mem[wr_addr][l] <= (l == int'(wr_row)) ? FIX_ONE : '0;
				end
			end
		end
		if (cmd.issue) begin
			rd_s1 <= coef_mem[cmd.issue_row];
		end
	end

	// mark rows that hold loaded coefficients
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
		end else if (cmd.coef_wr) begin
			row_vld_q[wr_addr] <= 1'b1;
		end
	end

	// attribute mask, slot counter, pipeline valids, overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= '0;
			slot_q <= '0;
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			ovf_q  <= 1'b0;
		end else begin
			if (cfg_wr) begin
				attr_q <= cfg_data;
			end
			if (cmd.capture) begin
				slot_q <= slot_last ? '0 : slot_q + SLOT_W'(1);
			end
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			if (cmd.capture) begin
				ovf_q <= 1'b0;
			end else if (v_s2) begin
				ovf_q <= ovf_q | ovf_s2;
			end
		end
	end

	// latch the vertex, dropping absent attributes
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			pos_q[0]   <= in_data.pos_x;
			pos_q[1]   <= in_data.pos_y;
			pos_q[2]   <= in_data.pos_z;
			color_q[0] <= attr_q[ATTR_COLOR_BIT] ? in_data.color_r : '0;
			color_q[1] <= attr_q[ATTR_COLOR_BIT] ? in_data.color_g : '0;
			color_q[2] <= attr_q[ATTR_COLOR_BIT] ? in_data.color_b : '0;
			color_q[3] <= attr_q[ATTR_COLOR_BIT] ? in_data.color_a : '0;
			tex_q[0]   <= attr_q[ATTR_TEX_BIT] ? in_data.tex_u : '0;
			tex_q[1]   <= attr_q[ATTR_TEX_BIT] ? in_data.tex_v : '0;
			last_q     <= slot_last;
		end
	end

	// carry the row tag beside the read data
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			row_s1 <= cmd.issue_row;
			vld_s1 <= row_vld_q[cmd.issue_row];
		end
		row_s2 <= row_s1;
	end

	// pick coefficients and vector, multiply four lanes
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			if (vld_s1) begin
				coef_s1[l] = $signed(rd_s1[l]);
			end else begin
				coef_s1[l] = (l == int'(row_s1[1:0])) ? FIX_ONE : '0;
			end
			if (row_s1[ROW_AW-1]) begin
				vec_s1[l] = mid_q[l];
			end else if (l < 3) begin
				vec_s1[l] = pos_q[l];
			end else begin
				vec_s1[l] = FIX_ONE;
			end
			prod_s1[l] = coef_s1[l] * vec_s1[l];
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			for (int l = 0; l < LANES; l++) begin
				prod_s2[l] <= prod_s1[l];
			end
		end
	end

	// add four products, floor to the fixed-point grid, saturate
	always_comb begin
		sum_s2 = SUM_W'(prod_s2[0]) + SUM_W'(prod_s2[1])
			+ SUM_W'(prod_s2[2]) + SUM_W'(prod_s2[3]);
		sh_s2 = SH_W'(sum_s2 >>> FRAC_BITS);
		ovf_s2 = 1'b0;
		if (sh_s2 > SAT_HI) begin
			sat_s2 = SAT_HI[COEF_W-1:0];
			ovf_s2 = 1'b1;
		end else if (sh_s2 < SAT_LO) begin
			sat_s2 = SAT_LO[COEF_W-1:0];
			ovf_s2 = 1'b1;
		end else begin
			sat_s2 = sh_s2[COEF_W-1:0];
		end
	end

	// store the row result in the model or the projection vector
	always_ff @(posedge clk) begin
		if (v_s2) begin
			if (row_s2[ROW_AW-1]) begin
				clip_q[row_s2[1:0]] <= sat_s2;
			end else begin
				mid_q[row_s2[1:0]] <= sat_s2;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data.clip_x        <= clip_q[0];
			out_data.clip_y        <= clip_q[1];
			out_data.clip_z        <= clip_q[2];
			out_data.clip_w        <= clip_q[3];
			out_data.out_color_r   <= color_q[0];
			out_data.out_color_g   <= color_q[1];
			out_data.out_color_b   <= color_q[2];
			out_data.out_color_a   <= color_q[3];
			out_data.out_tex_u     <= tex_q[0];
			out_data.out_tex_v     <= tex_q[1];
			out_data.triangle_last <= last_q;
			out_data.overflow      <= ovf_q;
		end
	end

endmodule

FILE: hw/rtl/vertex_transform_stage_unit.sv
// Top level of the fixed-function 4x4 vertex transform stage.
// Depends on vts_pkg, vts_in_if, vts_out_if, vts_cfg_if, vts_ctrl and vts_dp.
//
//   channel   dir  beat                               accepted when
//   vtx_in    in   coefficient load or vertex          vtx_in.valid && vtx_in.ready
//   res_out   out  clip position, attributes, flags    res_out.valid && res_out.ready
//   cfg       in   attribute mask                      cfg.valid && cfg.ready
//
// A load beat leaves the controller idle. A vertex blocks the next accept until
// it is done: one four-lane dot product unit with a three-stage pipeline runs
// four model rows, waits for the last model row, then runs four projection rows.
// Reset (arst_n low) restores identity matrices, slot zero and an empty mask.
// The finished vertex sits in an output register; a stalled result only holds
// the controller in its final step, and cfg is always ready.
module vertex_transform_stage_unit (
	input logic         clk,
	input logic         arst_n,
	vts_in_if.sink      vtx_in,
	vts_out_if.source   res_out,
	vts_cfg_if.sink     cfg
);
	import vts_pkg::*;

	vts_cmd_t cmd;

	assign cfg.ready = 1'b1;

	vts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vtx_in.valid),
		.in_opcode (vtx_in.data.opcode),
		.in_ready  (vtx_in.ready),
		.out_valid (res_out.valid),
		.out_ready (res_out.ready),
		.cmd       (cmd)
	);

	vts_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (vtx_in.data),
		.cfg_wr   (cfg.valid),
		.cfg_data (cfg.data),
		.out_data (res_out.data)
	);

endmodule
